/* src/kfis_pkg.sv */
// ----------------------------------------------------------------------------
// kfis_pkg
// Shared types and constants for the keyframe index search block.
// ----------------------------------------------------------------------------
package kfis_pkg;

  // Request codes carried on the input tuser
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_BEFORE = 2'd1;
  localparam logic [1:0] REQ_AFTER  = 2'd2;

  // Fixed field widths of the stream beats
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned STRM_W   = 16;
  localparam int unsigned TS_W     = 64;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned IN_DATA_W  = 176;
  localparam int unsigned OUT_DATA_W = 64;

  // Input tdata bit offsets
  localparam int unsigned OFS_SLOT   = 0;
  localparam int unsigned OFS_LSTRM  = 10;
  localparam int unsigned OFS_LKEY   = 26;
  localparam int unsigned OFS_LTS    = 27;
  localparam int unsigned OFS_QSTRM  = 91;
  localparam int unsigned OFS_QTIME  = 107;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

/* src/keyframe_index_search.sv */
// ----------------------------------------------------------------------------
// keyframe_index_search
// Packet index table in one synchronous RAM with a sequential keyframe scan.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one beat per request. in_tuser holds the request kind (load,
//            keyframe-before query, keyframe-after query). in_tdata holds
//            the slot, load entry fields and query fields.
//   out_*  : one beat per request. out_tuser is the found flag, out_tdata
//            the matching timestamp (zero when nothing found or for loads).
//   cfg_*  : writes entry_count (entries in use); write only while idle.
// Sequencing:
//   A load goes through DONE into the output register. A query
//   reads the table RAM one entry per cycle through its single read port,
//   scanning up to N = min(entry_count, MAX_ENTRIES) entries; it
//   stops early on the first match in scan order.
//   One request is in flight at a time; the next is accepted as soon as
//   the result has moved into the output register.
// Reset: clears the sequencer, the output valid and entry_count. The
//   table RAM is not cleared; entries are valid only after being loaded.
// Stall: a stalled output holds its beat; a finished result waits in the
//   sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module keyframe_index_search
  import kfis_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned STREAM_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tuser: req_type[1:0]
  input  logic [REQ_W-1:0]      in_tuser,
  // in_tdata: entry_slot[9:0], load_stream[25:10], load_keyframe[26],
  //           load_timestamp[90:27], query_stream[106:91],
  //           query_time[170:107], zero pad[175:171]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tuser: found[0]
  output logic                  out_tuser,
  // out_tdata: keyframe_time[63:0]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [COUNT_W-1:0]    cfg_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready
);

  localparam int unsigned AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNW = AW + 1;
  localparam int unsigned CW  = (CNW > COUNT_W) ? CNW : COUNT_W;
  localparam int unsigned SW  = (STREAM_BITS < STRM_W) ? STREAM_BITS : STRM_W;
  localparam int unsigned EW  = SW + 1 + TS_W;

  // Input field views
  logic [REQ_W-1:0]  req_type;
  logic [SLOT_W-1:0] entry_slot;
  logic [SW-1:0]     load_stream;
  logic              load_keyframe;
  logic [TS_W-1:0]   load_timestamp;
  logic [SW-1:0]     query_stream;
  logic [TS_W-1:0]   query_time;

  assign req_type       = in_tuser;
  assign entry_slot     = in_tdata[OFS_SLOT +: SLOT_W];
  assign load_stream    = in_tdata[OFS_LSTRM +: SW];
  assign load_keyframe  = in_tdata[OFS_LKEY];
  assign load_timestamp = in_tdata[OFS_LTS +: TS_W];
  assign query_stream   = in_tdata[OFS_QSTRM +: SW];
  assign query_time     = in_tdata[OFS_QTIME +: TS_W];

  // Registers
  state_t            state_r, state_nxt;
  logic [COUNT_W-1:0] entry_count_r;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [CNW-1:0]    iss_left_r, iss_left_nxt;
  logic              dir_up_r, dir_up_nxt;
  logic [SW-1:0]     q_stream_r, q_stream_nxt;
  logic [TS_W-1:0]   q_time_r, q_time_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic              res_found_r, res_found_nxt;
  logic [TS_W-1:0]   res_time_r, res_time_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r;
  logic [TS_W-1:0]   out_time_r;

  // Table RAM: {stream, keyframe, timestamp}
  logic [EW-1:0]     mem [MAX_ENTRIES];
  logic [EW-1:0]     rd_data_r;

  // Handshakes
  logic in_acc;
  logic out_load;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Saturated entry count
  logic [CW-1:0]  cnt_ext;
  logic [CNW-1:0] cnt_sat;
  assign cnt_ext = CW'(entry_count_r);
  assign cnt_sat = (cnt_ext > CW'(MAX_ENTRIES)) ? CNW'(MAX_ENTRIES) : CNW'(cnt_ext);

  // Slot range check for loads
  logic [CW-1:0] slot_ext;
  logic          slot_ok;
  logic [AW-1:0] wr_addr;
  assign slot_ext = CW'(entry_slot);
  assign slot_ok  = slot_ext < CW'(MAX_ENTRIES);
  assign wr_addr  = AW'(slot_ext);

  // Match check on the entry read last cycle
  logic [SW-1:0]   rd_stream;
  logic            rd_key;
  logic [TS_W-1:0] rd_ts;
  logic            ts_ok;
  logic            hit;
  logic            issue;
  assign rd_stream = rd_data_r[EW-1 -: SW];
  assign rd_key    = rd_data_r[TS_W];
  assign rd_ts     = rd_data_r[TS_W-1:0];
  assign ts_ok     = dir_up_r ? ($signed(q_time_r) < $signed(rd_ts))
                              : ($signed(rd_ts) < $signed(q_time_r));
  assign hit       = rd_vld_r && rd_key && (rd_stream == q_stream_r) && ts_ok;
  assign issue     = (state_r == ST_SCAN) && (iss_left_r != '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if ((req_type == REQ_BEFORE || req_type == REQ_AFTER) && cnt_sat != '0) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (hit || (rd_vld_r && rd_last_r)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    addr_nxt      = addr_r;
    iss_left_nxt  = iss_left_r;
    dir_up_nxt    = dir_up_r;
    q_stream_nxt  = q_stream_r;
    q_time_nxt    = q_time_r;
    res_found_nxt = res_found_r;
    res_time_nxt  = res_time_r;
    rd_vld_nxt    = 1'b0;
    rd_last_nxt   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dir_up_nxt    = (req_type == REQ_AFTER);
          q_stream_nxt  = query_stream;
          q_time_nxt    = query_time;
          iss_left_nxt  = cnt_sat;
          addr_nxt      = (req_type == REQ_AFTER) ? '0 : AW'(cnt_sat - CNW'(1));
          res_found_nxt = 1'b0;
          res_time_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_found_nxt = 1'b1;
          res_time_nxt  = rd_ts;
        end else if (!(rd_vld_r && rd_last_r) && issue) begin
          // one RAM read per cycle, walking in scan order
          rd_vld_nxt   = 1'b1;
          rd_last_nxt  = (iss_left_r == CNW'(1));
          iss_left_nxt = iss_left_r - CNW'(1);
          addr_nxt     = dir_up_r ? addr_r + AW'(1) : addr_r - AW'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register next value
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= '0;
      rd_vld_r      <= 1'b0;
      rd_last_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        entry_count_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    iss_left_r  <= iss_left_nxt;
    dir_up_r    <= dir_up_nxt;
    q_stream_r  <= q_stream_nxt;
    q_time_r    <= q_time_nxt;
    res_found_r <= res_found_nxt;
    res_time_r  <= res_time_nxt;
    if (out_load) begin
      out_found_r <= res_found_r;
      out_time_r  <= res_time_r;
    end
  end

  // Table RAM: write on an accepted load, registered read at the scan address.
  // Writes happen only in idle; the read port samples every cycle, but its data is used only while scanning.
  always_ff @(posedge clk) begin
    if (in_acc && req_type == REQ_LOAD && slot_ok) begin
      mem[wr_addr] <= {load_stream, load_keyframe, load_timestamp};
    end
    rd_data_r <= mem[addr_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_time_r;

`ifndef SYNTH
  // Read data only arrives after a scan cycle
  a_rd_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r) == ST_SCAN)
    else $error("read data valid outside a scan");

  // Leaving DONE always hands a beat to the output register
  a_done_hands_off: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && state_nxt == ST_IDLE) |=> out_valid_r)
    else $error("result lost on leaving DONE");

  // Issue counter never exceeds table depth
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> CW'(iss_left_r) <= CW'(MAX_ENTRIES))
    else $error("scan counter out of range");

  // Query on a non-empty table starts a scan
  a_query_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (req_type == REQ_BEFORE || req_type == REQ_AFTER) && cnt_sat != '0)
      |=> state_r == ST_SCAN)
    else $error("query did not start a scan");
`endif

endmodule
